@@ src/cln_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_pkg
// Shared types, codes and constants of the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
package cln_pkg;

  // Display geometry
  localparam int LAST_COLUMN = 15;
  localparam int ROW_COUNT   = 2;

  // Command codes
  localparam logic [1:0] CMD_INIT   = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_CURSOR = 2'd2;
  localparam logic [1:0] CMD_CHAR   = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ENABLE_HIGH = 3'd0;
  localparam logic [2:0] REG_SETTLE      = 3'd1;
  localparam logic [2:0] REG_CLEAR_WAIT  = 3'd2;
  localparam logic [2:0] REG_POWER_UP    = 3'd3;
  localparam logic [2:0] REG_FIRST_WAKE  = 3'd4;
  localparam logic [2:0] REG_WAKE        = 3'd5;

  // Register reset values
  localparam logic [15:0] SETTLE_RST     = 16'd50;
  localparam logic [15:0] CLEAR_WAIT_RST = 16'd2000;
  localparam logic [15:0] POWER_UP_RST   = 16'd50000;
  localparam logic [15:0] FIRST_WAKE_RST = 16'd4500;
  localparam logic [15:0] WAKE_RST       = 16'd150;

  // Instruction bytes and wake nibbles
  localparam logic [7:0] BYTE_FUNCTION_SET = 8'h28;
  localparam logic [7:0] BYTE_DISPLAY_ON   = 8'h0C;
  localparam logic [7:0] BYTE_ENTRY_MODE   = 8'h06;
  localparam logic [7:0] BYTE_CLEAR        = 8'h01;
  localparam logic [7:0] BYTE_SET_DDRAM    = 8'h80;
  localparam logic [7:0] ROW_ADDR_STEP     = 8'h40;
  localparam logic [3:0] NIB_WAKE          = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT      = 4'h2;

  // Strobe step numbering
  localparam int          STEP_W         = 4;
  localparam logic [3:0]  STEP_INIT_LAST = 4'd11;
  localparam logic [3:0]  STEP_BYTE_LAST = 4'd1;

  typedef struct packed {
    logic             load_item;  // latch a new command
    logic             load_out;   // load the strobe of the current step
    logic [STEP_W-1:0] step;
  } cln_ctl_t;

  typedef struct packed {
    logic last_step;
  } cln_sts_t;

endpackage

@@ src/cln_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_ctrl
// Controller: takes a command, then walks its strobe steps one per cycle
// into the output register as room allows.
// ----------------------------------------------------------------------------
module cln_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  output cln_pkg::cln_ctl_t ctl,
  input  cln_pkg::cln_sts_t sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                      state;
  logic [cln_pkg::STEP_W-1:0] step;
  logic                      room;

  assign room     = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE);

  assign ctl.load_item = in_valid && in_ready;
  assign ctl.load_out  = (state == ST_RUN) && room;
  assign ctl.step      = step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (ctl.load_item) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (ctl.load_out) begin
            if (sts.last_step) begin
              state <= ST_IDLE;
            end
            step <= step + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ src/cln_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cln_datapath
// Datapath: configuration registers, latched command, strobe decode and
// output register.
// ----------------------------------------------------------------------------
module cln_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic [1:0]        command,
  input  logic [7:0]        column,
  input  logic [7:0]        row,
  input  logic [7:0]        char_code,
  input  cln_pkg::cln_ctl_t ctl,
  output cln_pkg::cln_sts_t sts,
  output logic              register_select,
  output logic [3:0]        nibble,
  output logic [15:0]       wait_before_us,
  output logic [16:0]       wait_after_us,
  output logic              last_strobe
);

  localparam logic [7:0] COL_MAX = 8'(cln_pkg::LAST_COLUMN);
  localparam logic [7:0] ROW_MAX = 8'(cln_pkg::ROW_COUNT - 1);

  logic [15:0] settle_us;
  logic [15:0] clear_wait_us;
  logic [15:0] power_up_wait_us;
  logic [15:0] first_wake_wait_us;
  logic [15:0] wake_wait_us;

  logic [1:0]  cmd;
  logic [7:0]  byte_val;   // byte sent by clear, cursor and char commands

  logic [7:0]  col_c;
  logic [7:0]  row_c;
  logic [7:0]  cursor_byte;

  logic [7:0]  tx_byte;
  logic        s_rs;
  logic [3:0]  s_nib;
  logic [15:0] s_before;
  logic [15:0] s_extra;
  logic        s_last;

  // configuration; the enable-high time is accepted but drives no output
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_us          <= cln_pkg::SETTLE_RST;
      clear_wait_us      <= cln_pkg::CLEAR_WAIT_RST;
      power_up_wait_us   <= cln_pkg::POWER_UP_RST;
      first_wake_wait_us <= cln_pkg::FIRST_WAKE_RST;
      wake_wait_us       <= cln_pkg::WAKE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cln_pkg::REG_ENABLE_HIGH: ;
        cln_pkg::REG_SETTLE:      settle_us          <= cfg_data;
        cln_pkg::REG_CLEAR_WAIT:  clear_wait_us      <= cfg_data;
        cln_pkg::REG_POWER_UP:    power_up_wait_us   <= cfg_data;
        cln_pkg::REG_FIRST_WAKE:  first_wake_wait_us <= cfg_data;
        cln_pkg::REG_WAKE:        wake_wait_us       <= cfg_data;
        default: ;
      endcase
    end
  end

  // cursor address: clamp, row offset, set-DDRAM bit
  assign col_c       = (column > COL_MAX) ? COL_MAX : column;
  assign row_c       = (row > ROW_MAX) ? ROW_MAX : row;
  assign cursor_byte = cln_pkg::BYTE_SET_DDRAM | 8'((row_c << 6) + col_c);

  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd <= command;
      case (command)
        cln_pkg::CMD_CLEAR:  byte_val <= cln_pkg::BYTE_CLEAR;
        cln_pkg::CMD_CURSOR: byte_val <= cursor_byte;
        default:             byte_val <= char_code;
      endcase
    end
  end

  assign sts.last_step = (cmd == cln_pkg::CMD_INIT) ?
                         (ctl.step == cln_pkg::STEP_INIT_LAST) :
                         (ctl.step == cln_pkg::STEP_BYTE_LAST);

  // strobe decode for the current step
  always_comb begin
    s_rs     = 1'b0;
    s_before = '0;
    s_extra  = '0;
    s_last   = sts.last_step;
    tx_byte  = byte_val;
    if (cmd == cln_pkg::CMD_INIT) begin
      case (ctl.step[3:1])
        3'd2:    tx_byte = cln_pkg::BYTE_FUNCTION_SET;
        3'd3:    tx_byte = cln_pkg::BYTE_DISPLAY_ON;
        3'd4:    tx_byte = cln_pkg::BYTE_ENTRY_MODE;
        default: tx_byte = cln_pkg::BYTE_CLEAR;
      endcase
      // bytes start on an even step, so step[0] picks the low nibble
      s_nib = ctl.step[0] ? tx_byte[3:0] : tx_byte[7:4];
      case (ctl.step)
        4'd0: begin
          s_nib    = cln_pkg::NIB_WAKE;
          s_before = power_up_wait_us;
          s_extra  = first_wake_wait_us;
        end
        4'd1, 4'd2: begin
          s_nib   = cln_pkg::NIB_WAKE;
          s_extra = wake_wait_us;
        end
        4'd3: s_nib = cln_pkg::NIB_FOUR_BIT;
        cln_pkg::STEP_INIT_LAST: s_extra = clear_wait_us;
        default: ;
      endcase
    end else begin
      s_rs  = (cmd == cln_pkg::CMD_CHAR);
      s_nib = ctl.step[0] ? tx_byte[3:0] : tx_byte[7:4];
      if (ctl.step[0] && (cmd == cln_pkg::CMD_CLEAR)) begin
        s_extra = clear_wait_us;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      register_select <= s_rs;
      nibble          <= s_nib;
      wait_before_us  <= s_before;
      wait_after_us   <= {1'b0, settle_us} + {1'b0, s_extra};
      last_strobe     <= s_last;
    end
  end

endmodule

@@ src/char_lcd_nibble_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer
// Turns LCD commands into the enable strobes of a 4-bit character LCD bus.
// The first strobe is loaded into the output register once the controller is in
// its run state; then one strobe per cycle from the step counter while the output
// has room. A new command is taken only after the last strobe of the previous one.
// Reset: synchronous; configuration registers return to defaults, nothing in flight.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // column[7:0], row[15:8], char_code[23:16]
  input  logic [1:0]  s_axis_tuser,   // command[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // nibble[3:0], wait_before_us[19:4],
                                      // wait_after_us[36:20], zero[39:37]
  output logic        m_axis_tuser,   // register_select
  output logic        m_axis_tlast,   // last_strobe
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cln_pkg::cln_ctl_t ctl;
  cln_pkg::cln_sts_t sts;
  logic [3:0]        nibble;
  logic [15:0]       wait_before_us;
  logic [16:0]       wait_after_us;

  assign cfg_ready = 1'b1;

  cln_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .ctl       (ctl),
    .sts       (sts)
  );

  cln_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .command         (s_axis_tuser),
    .column          (s_axis_tdata[7:0]),
    .row             (s_axis_tdata[15:8]),
    .char_code       (s_axis_tdata[23:16]),
    .ctl             (ctl),
    .sts             (sts),
    .register_select (m_axis_tuser),
    .nibble          (nibble),
    .wait_before_us  (wait_before_us),
    .wait_after_us   (wait_after_us),
    .last_strobe     (m_axis_tlast)
  );

  assign m_axis_tdata = {3'b000, wait_after_us, wait_before_us, nibble};

endmodule
